[src/fqs_pkg.sv]
// ----------------------------------------------------------------------------
// FIFO queue with search: shared package
// Depth, widths, request and response types and codes of the queue.
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DATA_W      = 32;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_QUERY  = 2'd3
  } fqs_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH
  } fqs_state_e;

  typedef struct packed {
    fqs_op_e                   opcode;
    logic signed [DATA_W-1:0]  value;
  } fqs_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  front_value;
    logic [CNT_W-1:0]          entry_count;
    logic                      is_empty;
    logic                      found;
    logic                      push_dropped;
  } fqs_res_t;

endpackage

[src/fifo_queue_with_search_top.sv]
// ----------------------------------------------------------------------------
// FIFO queue with search
// Circular queue of signed words in a synchronous memory, with membership search.
// ----------------------------------------------------------------------------
// Push, refused push, query, a pop on an empty queue and a pop that leaves the
// queue empty give their response in the cycle after the request, and a new
// request follows at once. Any other pop reads the new front entry from memory.
// A search reads one stored entry per cycle through the memory read port,
// up to a match or the last entry; on an empty queue it answers like a query.
// Reset empties the queue; memory contents are not cleared.
module fifo_queue_with_search_top
  import fqs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  fqs_req_t req_i,
  output logic     busy,
  output logic     result_valid_o,
  output fqs_res_t res_o
);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  fqs_state_e        state_q, state_d;
  logic [IDX_W-1:0]  rd_q, rd_d, wr_q, wr_d, scan_q, scan_d, cnt_q, cnt_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [DATA_W-1:0] front_q, front_d, val_q, val_d;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic              res_valid_q, res_valid_d;
  fqs_res_t          res_q, res_d;
  logic              found_d, dropped_d;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_q] <= req_i.value;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    occ_d       = occ_q;
    front_d     = front_q;
    val_d       = val_q;
    scan_d      = scan_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = rd_q;
    res_valid_d = 1'b0;
    found_d     = 1'b0;
    dropped_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (req_i.opcode)
            OP_PUSH: begin
              res_valid_d = 1'b1;
              if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
                dropped_d = 1'b1;
              end else begin
                mem_we = 1'b1;
                wr_d   = next_idx(wr_q);
                occ_d  = occ_q + CNT_W'(1);
                if (occ_q == '0) begin
                  front_d = req_i.value;
                end
              end
            end
            OP_POP: begin
              if (occ_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                rd_d  = next_idx(rd_q);
                occ_d = occ_q - CNT_W'(1);
                if (occ_q == CNT_W'(1)) begin
                  res_valid_d = 1'b1;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = next_idx(rd_q);
                  state_d   = ST_POP;
                end
              end
            end
            OP_SEARCH: begin
              if (occ_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = rd_q;
                scan_d    = next_idx(rd_q);
                cnt_d     = '0;
                val_d     = req_i.value;
                state_d   = ST_SEARCH;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        front_d     = rd_data_q;
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SEARCH: begin
        if (rd_data_q == val_q) begin
          found_d     = 1'b1;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if ({1'b0, cnt_q} == CNT_W'(occ_q - CNT_W'(1))) begin
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = scan_q;
          scan_d    = next_idx(scan_q);
          cnt_d     = cnt_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.front_value  = (occ_d == '0) ? '1 : front_d;
    res_d.entry_count  = occ_d;
    res_d.is_empty     = (occ_d == '0);
    res_d.found        = found_d;
    res_d.push_dropped = dropped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      occ_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      occ_q       <= occ_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    val_q   <= val_d;
    scan_q  <= scan_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

endmodule

[src/fqs_checker.sv]
// ----------------------------------------------------------------------------
// FIFO queue with search: port checker
// Checks the responses seen on the ports of the queue over time.
// ----------------------------------------------------------------------------
module fqs_checker
  import fqs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input fqs_req_t req_i,
  input logic     busy,
  input logic     result_valid_o,
  input fqs_res_t res_o
);

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (res_o.is_empty == (res_o.entry_count == '0)))
    else $error("Empty flag disagrees with the entry count.");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.is_empty) |-> (res_o.front_value == -32'sd1))
    else $error("Empty queue reports a front value other than minus one.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (res_o.entry_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("Entry count exceeds the queue depth.");

  a_query_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.opcode == OP_QUERY)) |=> result_valid_o)
    else $error("Query request gave no response in the next cycle.");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(res_o.found && res_o.push_dropped))
    else $error("Found and push-dropped flags are both set.");

endmodule

bind fifo_queue_with_search_top fqs_checker u_fqs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .req_i          (req_i),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .res_o          (res_o)
);
